FILE: design/mrprb_pkg.sv
// Shared types and codes for the multi-reader ring buffer.
`timescale 1ns / 1ps
package mrprb_pkg;

  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_FORK   = 3'd1;
  localparam logic [2:0] CMD_WRITE  = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_FLUSH  = 3'd4;
  localparam logic [2:0] CMD_CLOSE  = 3'd5;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_ATT    = 3'd1;
  localparam logic [2:0] ST_END_CLOSED = 3'd2;
  localparam logic [2:0] ST_NO_SLOT    = 3'd3;
  localparam logic [2:0] ST_NO_PARENT  = 3'd4;

  localparam logic [6:0] MAX_BURST = 7'd64;

  typedef enum logic [2:0] {
    OP_CREATE, OP_FORK, OP_WRITE, OP_READ, OP_FLUSH, OP_CLOSE, OP_NONE
  } op_t;

  typedef enum logic [2:0] {
    BS_IDLE, BS_LOOK, BS_EXEC, BS_RADDR, BS_RDATA, BS_SCAN, BS_FLUSH
  } back_state_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] pid;
    logic [15:0] ppid;
    logic        end_sel;
    logic [7:0]  data;
    logic [6:0]  cnt;
    logic        blast;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data;
    logic        valid;
    logic [12:0] amount;
    logic        last;
  } res_t;

endpackage

FILE: design/mrprb_if.sv
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
interface mrprb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] pid;
  logic [15:0] parent_pid;
  logic        end_select;
  logic [7:0]  data_in;
  logic [6:0]  read_count;
  logic        burst_last;
  modport source (output valid, command, pid, parent_pid, end_select, data_in,
                  read_count, burst_last, input ready);
  modport sink (input valid, command, pid, parent_pid, end_select, data_in,
                read_count, burst_last, output ready);
endinterface

interface mrprb_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  data_out;
  logic        data_valid;
  logic [12:0] amount;
  logic        last;
  modport source (output valid, status, data_out, data_valid, amount, last,
                  input ready);
  modport sink (input valid, status, data_out, data_valid, amount, last,
                output ready);
endinterface

FILE: design/mrprb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mrprb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: design/mrprb_front.sv
// Front end: accept commands, decode them and queue them for the back end.
`timescale 1ns / 1ps
module mrprb_front (
  input  logic                clk,
  input  logic                rst_n,
  mrprb_in_if.sink            in_ch,
  output logic                q_valid,
  input  logic                q_ready,
  output mrprb_pkg::item_t    q_item
);
  mrprb_pkg::item_t q_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  mrprb_pkg::item_t dec;
  logic push, pop;

  // decode the command and clamp the read length
  always_comb begin
    dec.pid     = in_ch.pid;
    dec.ppid    = in_ch.parent_pid;
    dec.end_sel = in_ch.end_select;
    dec.data    = in_ch.data_in;
    dec.blast   = in_ch.burst_last;
    dec.cnt     = (in_ch.read_count > mrprb_pkg::MAX_BURST) ? mrprb_pkg::MAX_BURST
                                                              : in_ch.read_count;
    unique case (in_ch.command)
      mrprb_pkg::CMD_CREATE: dec.op = mrprb_pkg::OP_CREATE;
      mrprb_pkg::CMD_FORK:   dec.op = mrprb_pkg::OP_FORK;
      mrprb_pkg::CMD_WRITE:  dec.op = mrprb_pkg::OP_WRITE;
      mrprb_pkg::CMD_READ:   dec.op = mrprb_pkg::OP_READ;
      mrprb_pkg::CMD_FLUSH:  dec.op = mrprb_pkg::OP_FLUSH;
      mrprb_pkg::CMD_CLOSE:  dec.op = mrprb_pkg::OP_CLOSE;
      default:               dec.op = mrprb_pkg::OP_NONE;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_item  = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= dec;
    end
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: design/mrprb_back.sv
// Back end: slot table, ring storage and command sequencer.
`timescale 1ns / 1ps
module mrprb_back #(
  parameter int BUFFER_BYTES = 4096,
  parameter int NUM_CLIENTS  = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  mrprb_pkg::item_t q_item,
  mrprb_out_if.source      out_ch
);
  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int SW = $clog2(NUM_CLIENTS);
  localparam int NW = $clog2(NUM_CLIENTS + 1);
  localparam logic [CW-1:0] BB        = CW'(BUFFER_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_BYTES - 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_CLIENTS - 1);
  localparam logic [NW-1:0] NCL       = NW'(NUM_CLIENTS);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == LAST_ADDR) ? '0 : p + 1'b1;
  endfunction

  mrprb_pkg::back_state_t state_r, state_nxt;
  mrprb_pkg::item_t cur_r, cur_nxt;

  logic          act_r [NUM_CLIENTS], act_nxt [NUM_CLIENTS];
  logic          rop_r [NUM_CLIENTS], rop_nxt [NUM_CLIENTS];
  logic          wop_r [NUM_CLIENTS], wop_nxt [NUM_CLIENTS];
  logic [15:0]   own_r [NUM_CLIENTS], own_nxt [NUM_CLIENTS];
  logic [AW-1:0] rp_r  [NUM_CLIENTS], rp_nxt  [NUM_CLIENTS];
  logic [CW-1:0] unr_r [NUM_CLIENTS], unr_nxt [NUM_CLIENTS];
  logic [CW-1:0] con_r [NUM_CLIENTS], con_nxt [NUM_CLIENTS];

  logic [AW-1:0] wp_r, wp_nxt, crp_r, crp_nxt;
  logic [CW-1:0] free_r, free_nxt, m_r, m_nxt;
  logic [NW-1:0] cc_r, cc_nxt;
  logic [SW-1:0] s_r, p_r, f_r, scan_r, scan_nxt;
  logic          hs_r, hp_r, hf_r, any_r, any_nxt;
  logic [6:0]    n_r, n_nxt, rem_r, rem_nxt;
  logic          ov_r, ov_nxt;
  mrprb_pkg::res_t res_r, res_nxt;

  logic [SW-1:0] s_c, p_c, f_c;
  logic          hs_c, hp_c, hf_c;
  logic          out_free, rd_ok;
  logic [6:0]    n_c;
  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic [CW:0]   sum_c;

  mrprb_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(cur_r.data),
    .raddr(crp_r),
    .rdata(ram_rdata)
  );

  // pid match: lowest active slot wins; free slot: lowest inactive
  always_comb begin
    hs_c = 1'b0; hp_c = 1'b0; hf_c = 1'b0;
    s_c = '0; p_c = '0; f_c = '0;
    for (int i = NUM_CLIENTS - 1; i >= 0; i--) begin
      if (act_r[i] && own_r[i] == cur_r.pid) begin
        hs_c = 1'b1; s_c = SW'(i);
      end
      if (act_r[i] && own_r[i] == cur_r.ppid) begin
        hp_c = 1'b1; p_c = SW'(i);
      end
      if (!act_r[i]) begin
        hf_c = 1'b1; f_c = SW'(i);
      end
    end
  end

  assign out_free = !ov_r || out_ch.ready;
  assign rd_ok    = hs_r && rop_r[s_r];
  assign n_c      = (int'(unr_r[s_r]) < int'(cur_r.cnt)) ? 7'(unr_r[s_r]) : cur_r.cnt;
  assign q_ready  = (state_r == mrprb_pkg::BS_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mrprb_pkg::BS_IDLE:  if (q_valid) state_nxt = mrprb_pkg::BS_LOOK;
      mrprb_pkg::BS_LOOK:  state_nxt = mrprb_pkg::BS_EXEC;
      mrprb_pkg::BS_EXEC: begin
        priority if (cur_r.op == mrprb_pkg::OP_NONE) state_nxt = mrprb_pkg::BS_IDLE;
        else if (cur_r.op == mrprb_pkg::OP_READ && rd_ok && n_c != 7'd0)
          state_nxt = mrprb_pkg::BS_RADDR;
        else if (cur_r.op == mrprb_pkg::OP_FLUSH) state_nxt = mrprb_pkg::BS_SCAN;
        else if (out_free) state_nxt = mrprb_pkg::BS_IDLE;
        else state_nxt = mrprb_pkg::BS_EXEC;
      end
      mrprb_pkg::BS_RADDR: state_nxt = mrprb_pkg::BS_RDATA;
      mrprb_pkg::BS_RDATA: begin
        if (out_free) begin
          state_nxt = (rem_r == 7'd1) ? mrprb_pkg::BS_IDLE : mrprb_pkg::BS_RADDR;
        end
      end
      mrprb_pkg::BS_SCAN:  if (scan_r == LAST_SLOT) state_nxt = mrprb_pkg::BS_FLUSH;
      mrprb_pkg::BS_FLUSH: if (out_free) state_nxt = mrprb_pkg::BS_IDLE;
      default:             state_nxt = mrprb_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    act_nxt = act_r; rop_nxt = rop_r; wop_nxt = wop_r; own_nxt = own_r;
    rp_nxt = rp_r; unr_nxt = unr_r; con_nxt = con_r;
    wp_nxt = wp_r; free_nxt = free_r; cc_nxt = cc_r; crp_nxt = crp_r;
    m_nxt = m_r; any_nxt = any_r; scan_nxt = scan_r; n_nxt = n_r; rem_nxt = rem_r;
    cur_nxt = cur_r;
    ov_nxt = ov_r && !out_ch.ready;
    res_nxt = res_r;
    ram_we = 1'b0;
    sum_c = '0;
    unique case (state_r)
      mrprb_pkg::BS_IDLE: if (q_valid) cur_nxt = q_item;
      mrprb_pkg::BS_EXEC: begin
        // hold a waiting result until the receiver takes it
        if (out_free) begin
          res_nxt = '{status: mrprb_pkg::ST_OK, data: 8'd0, valid: 1'b0,
                      amount: 13'd0, last: 1'b1};
        end
        unique case (cur_r.op)
          mrprb_pkg::OP_CREATE: if (out_free) begin
            wp_nxt = '0; free_nxt = BB;
            for (int i = 0; i < NUM_CLIENTS; i++) begin
              act_nxt[i] = 1'b0; rop_nxt[i] = 1'b0; wop_nxt[i] = 1'b0;
              own_nxt[i] = '0; rp_nxt[i] = '0; unr_nxt[i] = '0; con_nxt[i] = '0;
            end
            act_nxt[0] = 1'b1; rop_nxt[0] = 1'b1; wop_nxt[0] = 1'b1;
            own_nxt[0] = cur_r.pid;
            cc_nxt = NW'(1);
            ov_nxt = 1'b1;
          end
          mrprb_pkg::OP_FORK: if (out_free) begin
            ov_nxt = 1'b1;
            if (!hs_r && (cc_r >= NCL || !hf_r)) begin
              res_nxt.status = mrprb_pkg::ST_NO_SLOT;
            end else begin
              if (!hs_r) begin
                // attach the child in the lowest free slot
                act_nxt[f_r] = 1'b1; rop_nxt[f_r] = 1'b0; wop_nxt[f_r] = 1'b0;
                own_nxt[f_r] = cur_r.pid; rp_nxt[f_r] = '0;
                unr_nxt[f_r] = '0; con_nxt[f_r] = '0;
                cc_nxt = cc_r + 1'b1;
              end
              if (!hp_r) begin
                // parent is the new child itself only if the pids match
                if (!(!hs_r && cur_r.ppid == cur_r.pid)) begin
                  res_nxt.status = mrprb_pkg::ST_NO_PARENT;
                end
              end else if (!cur_r.end_sel) begin
                rop_nxt[hs_r ? s_r : f_r] = rop_r[p_r];
                rp_nxt[hs_r ? s_r : f_r]  = rp_r[p_r];
                unr_nxt[hs_r ? s_r : f_r] = unr_r[p_r];
                con_nxt[hs_r ? s_r : f_r] = con_r[p_r];
              end else begin
                wop_nxt[hs_r ? s_r : f_r] = wop_r[p_r];
              end
            end
          end
          mrprb_pkg::OP_WRITE: if (out_free) begin
            ov_nxt = 1'b1;
            res_nxt.last = cur_r.blast;
            priority if (!hs_r) res_nxt.status = mrprb_pkg::ST_NOT_ATT;
            else if (!wop_r[s_r]) res_nxt.status = mrprb_pkg::ST_END_CLOSED;
            else if (free_r != '0) begin
              ram_we = 1'b1;
              wp_nxt = ring_next(wp_r);
              free_nxt = free_r - 1'b1;
              for (int i = 0; i < NUM_CLIENTS; i++) begin
                if (act_r[i] && unr_r[i] < BB) unr_nxt[i] = unr_r[i] + 1'b1;
              end
              res_nxt.amount = 13'd1;
            end
          end
          mrprb_pkg::OP_READ: begin
            if (rd_ok && n_c != 7'd0) begin
              n_nxt = n_c; rem_nxt = n_c; crp_nxt = rp_r[s_r];
            end else if (out_free) begin
              ov_nxt = 1'b1;
              priority if (!hs_r) res_nxt.status = mrprb_pkg::ST_NOT_ATT;
              else if (!rd_ok) res_nxt.status = mrprb_pkg::ST_END_CLOSED;
              else res_nxt.status = mrprb_pkg::ST_OK;
            end
          end
          mrprb_pkg::OP_FLUSH: begin
            scan_nxt = '0; any_nxt = 1'b0; m_nxt = '0;
          end
          mrprb_pkg::OP_CLOSE: if (out_free) begin
            ov_nxt = 1'b1;
            if (!hs_r) begin
              res_nxt.status = mrprb_pkg::ST_NOT_ATT;
            end else begin
              if (!cur_r.end_sel) rop_nxt[s_r] = 1'b0;
              else wop_nxt[s_r] = 1'b0;
              if ((cur_r.end_sel ? 1'b0 : 1'b1) | ~rop_r[s_r]) begin
                if ((cur_r.end_sel ? 1'b1 : 1'b0) | ~wop_r[s_r]) begin
                  act_nxt[s_r] = 1'b0;
                  if (cc_r != '0) cc_nxt = cc_r - 1'b1;
                end
              end
            end
          end
          default: ;
        endcase
      end
      // read address stays put until the byte is taken, so a stall keeps the data
      mrprb_pkg::BS_RADDR: ;
      mrprb_pkg::BS_RDATA: if (out_free) begin
        ov_nxt = 1'b1;
        res_nxt = '{status: mrprb_pkg::ST_OK, data: ram_rdata, valid: 1'b1,
                    amount: 13'd0, last: (rem_r == 7'd1)};
        rem_nxt = rem_r - 1'b1;
        crp_nxt = ring_next(crp_r);
        if (rem_r == 7'd1) begin
          rp_nxt[s_r]  = ring_next(crp_r);
          unr_nxt[s_r] = unr_r[s_r] - CW'(n_r);
          sum_c = {1'b0, con_r[s_r]} + (CW+1)'(n_r);
          con_nxt[s_r] = (sum_c > {1'b0, BB}) ? BB : sum_c[CW-1:0];
        end
      end
      mrprb_pkg::BS_SCAN: begin
        if (act_r[scan_r] && rop_r[scan_r] && (!any_r || con_r[scan_r] < m_r)) begin
          m_nxt = con_r[scan_r]; any_nxt = 1'b1;
        end
        scan_nxt = scan_r + 1'b1;
      end
      mrprb_pkg::BS_FLUSH: if (out_free) begin
        for (int i = 0; i < NUM_CLIENTS; i++) begin
          if (act_r[i] && rop_r[i]) con_nxt[i] = con_r[i] - m_r;
        end
        sum_c = {1'b0, free_r} + {1'b0, m_r};
        free_nxt = (sum_c > {1'b0, BB}) ? BB : sum_c[CW-1:0];
        ov_nxt = 1'b1;
        res_nxt = '{status: mrprb_pkg::ST_OK, data: 8'd0, valid: 1'b0,
                    amount: 13'(m_r), last: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; res_r <= res_nxt; crp_r <= crp_nxt;
    m_r <= m_nxt; any_r <= any_nxt; scan_r <= scan_nxt; n_r <= n_nxt; rem_r <= rem_nxt;
    if (state_r == mrprb_pkg::BS_LOOK) begin
      s_r <= s_c; p_r <= p_c; f_r <= f_c;
      hs_r <= hs_c; hp_r <= hp_c; hf_r <= hf_c;
    end
    if (!rst_n) begin
      state_r <= mrprb_pkg::BS_IDLE;
      ov_r <= 1'b0; wp_r <= '0; free_r <= BB; cc_r <= '0;
      for (int i = 0; i < NUM_CLIENTS; i++) begin
        act_r[i] <= 1'b0; rop_r[i] <= 1'b0; wop_r[i] <= 1'b0; own_r[i] <= '0;
        rp_r[i] <= '0; unr_r[i] <= '0; con_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt; wp_r <= wp_nxt; free_r <= free_nxt; cc_r <= cc_nxt;
      act_r <= act_nxt; rop_r <= rop_nxt; wop_r <= wop_nxt; own_r <= own_nxt;
      rp_r <= rp_nxt; unr_r <= unr_nxt; con_r <= con_nxt;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.status     = res_r.status;
  assign out_ch.data_out   = res_r.data;
  assign out_ch.data_valid = res_r.valid;
  assign out_ch.amount     = res_r.amount;
  assign out_ch.last       = res_r.last;
endmodule

FILE: design/multi_reader_persistent_ring_buffer_unit.sv
// Top level of the multi-reader ring buffer: front queue plus back sequencer.
`timescale 1ns / 1ps
// Usage:
//   in_ch carries one command beat (create, fork_end, write_byte, read,
//   flush, close_end) with its pid and operands; out_ch returns result beats,
//   the final one of each defined command marked by last (burst_last for writes).
//   A two-entry queue in the front accepts beats while the back is busy.
// Sequence:
//   Create, fork, write and close pass the back's dequeue, pid match over all
//   slots and execute states; the result is then registered onto out_ch.
//   A read of n bytes handles each byte as one registered read of the ring
//   memory followed by a beat into the output register.
//   Flush finds the minimum consumed count by a scan of one slot per cycle.
// Reset: rst_n (synchronous, low) empties the queue and detaches all slots;
//   ring contents are undefined until written and no clearing pass runs.
// Backpressure: while out_ch.ready is low the result stays in the output
//   register and the back holds; the front keeps taking beats until full.
module multi_reader_persistent_ring_buffer_unit #(
  parameter int BUFFER_BYTES = 4096,
  parameter int NUM_CLIENTS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  mrprb_in_if.sink    in_ch,
  mrprb_out_if.source out_ch
);
  logic             q_valid;
  logic             q_ready;
  mrprb_pkg::item_t q_item;

  // decode and buffer incoming commands
  mrprb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .q_item (q_item)
  );

  // execute one command at a time against the slot table and ring
  mrprb_back #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .NUM_CLIENTS (NUM_CLIENTS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .q_item (q_item),
    .out_ch (out_ch)
  );
endmodule

FILE: test/mrprb_checker.sv
// Result checker for the multi-reader ring buffer: predicts and compares beats.
`timescale 1ns / 1ps
module mrprb_checker #(
  parameter int BUFFER_BYTES = 4096,
  parameter int NUM_CLIENTS  = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  mrprb_in_if.sink   in_mon,
  mrprb_out_if.sink  out_mon,
  output int         fail_count,
  output int         pending_count
);
  typedef struct {
    logic [2:0]  status;
    logic [7:0]  data;
    logic        dvalid;
    logic [12:0] amount;
    logic        last;
  } beat_t;

  beat_t       due_q[$];
  logic [7:0]  ring[BUFFER_BYTES];
  int          wr_ptr, free_bytes, n_clients;
  bit          act[NUM_CLIENTS], rd_open[NUM_CLIENTS], wr_open[NUM_CLIENTS];
  int          owner[NUM_CLIENTS], rd_ptr[NUM_CLIENTS];
  int          unread[NUM_CLIENTS], consumed[NUM_CLIENTS];

  assign pending_count = due_q.size();

  function automatic void drop_slot(int i);
    act[i] = 0; rd_open[i] = 0; wr_open[i] = 0; owner[i] = 0;
    rd_ptr[i] = 0; unread[i] = 0; consumed[i] = 0;
  endfunction

  function automatic int slot_of(int pid);
    for (int i = 0; i < NUM_CLIENTS; i++)
      if (act[i] && owner[i] == pid) return i;
    return -1;
  endfunction

  function automatic void push(logic [2:0] st, int d, int v, int amt, int lst);
    beat_t b;
    b.status = st; b.data = d[7:0]; b.dvalid = v[0]; b.amount = amt[12:0];
    b.last = lst[0];
    due_q.push_back(b);
  endfunction

  // Apply one command to the shadow state and queue its result beats.
  function automatic void run_command(logic [2:0] cmd, int pid, int ppid, logic sel,
                                      logic [7:0] din, int cnt, logic blast);
    int s, p, n, m;
    bit any;
    case (cmd)
      mrprb_pkg::CMD_CREATE: begin
        wr_ptr = 0; free_bytes = BUFFER_BYTES;
        for (int i = 0; i < NUM_CLIENTS; i++) drop_slot(i);
        act[0] = 1; rd_open[0] = 1; wr_open[0] = 1; owner[0] = pid;
        n_clients = 1;
        push(mrprb_pkg::ST_OK, 0, 0, 0, 1);
      end
      mrprb_pkg::CMD_FORK: begin
        s = slot_of(pid);
        if (s < 0) begin
          if (n_clients < NUM_CLIENTS)
            for (int i = 0; i < NUM_CLIENTS; i++)
              if (!act[i] && s < 0) s = i;
          if (s < 0) begin
            push(mrprb_pkg::ST_NO_SLOT, 0, 0, 0, 1);
            return;
          end
          drop_slot(s);
          act[s] = 1; owner[s] = pid; n_clients++;
        end
        p = slot_of(ppid);
        if (p < 0) begin
          push(mrprb_pkg::ST_NO_PARENT, 0, 0, 0, 1);
          return;
        end
        if (!sel) begin
          rd_open[s] = rd_open[p]; rd_ptr[s] = rd_ptr[p];
          unread[s] = unread[p]; consumed[s] = consumed[p];
        end else begin
          wr_open[s] = wr_open[p];
        end
        push(mrprb_pkg::ST_OK, 0, 0, 0, 1);
      end
      mrprb_pkg::CMD_WRITE: begin
        s = slot_of(pid);
        if (s < 0) push(mrprb_pkg::ST_NOT_ATT, 0, 0, 0, int'(blast));
        else if (!wr_open[s]) push(mrprb_pkg::ST_END_CLOSED, 0, 0, 0, int'(blast));
        else if (free_bytes == 0) push(mrprb_pkg::ST_OK, 0, 0, 0, int'(blast));
        else begin
          ring[wr_ptr] = din;
          wr_ptr = (wr_ptr + 1) % BUFFER_BYTES;
          free_bytes--;
          for (int i = 0; i < NUM_CLIENTS; i++)
            if (act[i] && unread[i] < BUFFER_BYTES) unread[i]++;
          push(mrprb_pkg::ST_OK, 0, 0, 1, int'(blast));
        end
      end
      mrprb_pkg::CMD_READ: begin
        s = slot_of(pid);
        if (s < 0) push(mrprb_pkg::ST_NOT_ATT, 0, 0, 0, 1);
        else if (!rd_open[s]) push(mrprb_pkg::ST_END_CLOSED, 0, 0, 0, 1);
        else begin
          if (cnt > int'(mrprb_pkg::MAX_BURST)) cnt = int'(mrprb_pkg::MAX_BURST);
          n = cnt < unread[s] ? cnt : unread[s];
          if (n == 0) push(mrprb_pkg::ST_OK, 0, 0, 0, 1);
          for (int k = 0; k < n; k++) begin
            push(mrprb_pkg::ST_OK, int'(ring[rd_ptr[s]]), 1, 0, (k + 1 == n) ? 1 : 0);
            rd_ptr[s] = (rd_ptr[s] + 1) % BUFFER_BYTES;
          end
          unread[s] -= n;
          consumed[s] += n;
          if (consumed[s] > BUFFER_BYTES) consumed[s] = BUFFER_BYTES;
        end
      end
      mrprb_pkg::CMD_FLUSH: begin
        m = 0; any = 0;
        for (int i = 0; i < NUM_CLIENTS; i++)
          if (act[i] && rd_open[i] && (!any || consumed[i] < m)) begin
            m = consumed[i]; any = 1;
          end
        for (int i = 0; i < NUM_CLIENTS; i++)
          if (act[i] && rd_open[i]) consumed[i] -= m;
        free_bytes += m;
        if (free_bytes > BUFFER_BYTES) free_bytes = BUFFER_BYTES;
        push(mrprb_pkg::ST_OK, 0, 0, m, 1);
      end
      mrprb_pkg::CMD_CLOSE: begin
        s = slot_of(pid);
        if (s < 0) push(mrprb_pkg::ST_NOT_ATT, 0, 0, 0, 1);
        else begin
          if (!sel) rd_open[s] = 0; else wr_open[s] = 0;
          if (!rd_open[s] && !wr_open[s]) begin
            act[s] = 0;
            if (n_clients > 0) n_clients--;
          end
          push(mrprb_pkg::ST_OK, 0, 0, 0, 1);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    beat_t exp_b;
    if (!rst_n) begin
      due_q.delete();
      fail_count <= 0;
      wr_ptr = 0; free_bytes = BUFFER_BYTES; n_clients = 0;
      for (int i = 0; i < NUM_CLIENTS; i++) drop_slot(i);
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (due_q.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: unexpected result beat status=%0d data=%0h",
                     out_mon.status, out_mon.data_out);
          fail_count <= fail_count + 1;
        end else begin
          exp_b = due_q.pop_front();
          if (out_mon.status !== exp_b.status || out_mon.data_out !== exp_b.data ||
              out_mon.data_valid !== exp_b.dvalid || out_mon.amount !== exp_b.amount ||
              out_mon.last !== exp_b.last) begin
            if (fail_count < 10)
              $display({"ERROR: exp st=%0d d=%0h v=%0b a=%0d l=%0b",
                        " got st=%0d d=%0h v=%0b a=%0d l=%0b"},
                       exp_b.status, exp_b.data, exp_b.dvalid, exp_b.amount, exp_b.last,
                       out_mon.status, out_mon.data_out, out_mon.data_valid,
                       out_mon.amount, out_mon.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        run_command(in_mon.command, int'(in_mon.pid), int'(in_mon.parent_pid),
                    in_mon.end_select, in_mon.data_in, int'(in_mon.read_count),
                    in_mon.burst_last);
    end
  end
endmodule

FILE: test/tb_top.sv
// Stimulus and verdict for the multi-reader ring buffer.
`timescale 1ns / 1ps
module tb_top;
  localparam int RING_BYTES = 4096;
  localparam int SLOTS      = 32;
  localparam int IDLE_LIMIT = 20000;
  // command codes the block ignores
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending_count;
  int   idle_cycles = 0;
  bit   hold_off = 0;     // long receiver stall requested by the stimulus
  bit   in_stall = 1;     // sender-side gap

  mrprb_in_if  in_ch();
  mrprb_out_if out_ch();

  multi_reader_persistent_ring_buffer_unit #(.BUFFER_BYTES(RING_BYTES),
                                             .NUM_CLIENTS(SLOTS)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  mrprb_checker #(.BUFFER_BYTES(RING_BYTES), .NUM_CLIENTS(SLOTS)) i_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    in_ch.valid = 0; in_ch.command = mrprb_pkg::CMD_FLUSH; in_ch.pid = 0;
    in_ch.parent_pid = 0; in_ch.end_select = 0; in_ch.data_in = 0;
    in_ch.read_count = 1; in_ch.burst_last = 0;
    out_ch.ready = 0;
  end

  // Receiver: stall on its own pattern; a long hold-off overrides it.
  always @(posedge clk) begin
    int phase;
    phase = $urandom_range(0, 15);
    if (hold_off) out_ch.ready <= 0;
    else if (phase < 4) out_ch.ready <= 0;
    else if (phase < 6) out_ch.ready <= ($urandom_range(0, 1) == 1);
    else out_ch.ready <= 1;
  end

  // Watchdog: count cycles in which no beat moves on either channel, outside a hold-off.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one beat and hold it until the handshake; after a burst ends, add a random gap before.
  task automatic send_beat(logic [2:0] cmd, logic [15:0] pid, logic [15:0] ppid,
                           logic sel, logic [7:0] din, logic [6:0] cnt, logic blast);
    if (in_stall) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.command <= cmd; in_ch.pid <= pid; in_ch.parent_pid <= ppid;
    in_ch.end_select <= sel; in_ch.data_in <= din; in_ch.read_count <= cnt;
    in_ch.burst_last <= blast;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // end bursts at random, start gaps
    in_stall = ($urandom_range(0, 7) == 0);
  endtask

  task automatic drain_results();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Keep reads within written data: each slot only ever reads bytes written
  // after its creation point, so reads never reach unwritten ring entries.
  initial begin
    logic [15:0] pids[4];
    logic [3:0]  pick;
    int          k;
    pids = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001};
    repeat (9) @(posedge clk);
    rst_n <= 1;
    in_stall = 0;
    // Directed: commands before any create, then every operation and edge case.
    send_beat(mrprb_pkg::CMD_WRITE, 16'h0001, 16'd0, 1'b0, 8'h00, 7'd1, 1'b1);
    send_beat(mrprb_pkg::CMD_READ, 16'h0001, 16'd0, 1'b0, 8'd0, 7'd1, 1'b0);
    send_beat(mrprb_pkg::CMD_CLOSE, 16'h0001, 16'd0, 1'b1, 8'd0, 7'd1, 1'b0);
    send_beat(mrprb_pkg::CMD_FLUSH, 16'd0, 16'd0, 1'b0, 8'd0, 7'd1, 1'b0);
    send_beat(CMD_UNUSED_6, 16'h0001, 16'd0, 1'b0, 8'd0, 7'd1, 1'b0);
    send_beat(CMD_UNUSED_7, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 7'h7F, 1'b1);
    send_beat(mrprb_pkg::CMD_CREATE, 16'hFFFF, 16'd0, 1'b0, 8'd0, 7'd1, 1'b0);
    send_beat(mrprb_pkg::CMD_READ, 16'hFFFF, 16'd0, 1'b0, 8'd0, 7'd64, 1'b0);
    send_beat(mrprb_pkg::CMD_WRITE, 16'hFFFF, 16'd0, 1'b0, 8'hFF, 7'd1, 1'b0);
    send_beat(mrprb_pkg::CMD_WRITE, 16'hFFFF, 16'd0, 1'b0, 8'h00, 7'd1, 1'b1);
    send_beat(mrprb_pkg::CMD_FORK, 16'h0000, 16'hFFFF, 1'b0, 8'd0, 7'd1, 1'b0);
    send_beat(mrprb_pkg::CMD_FORK, 16'h0000, 16'hFFFF, 1'b1, 8'd0, 7'd1, 1'b0);
    send_beat(mrprb_pkg::CMD_FORK, 16'h0002, 16'h7777, 1'b0, 8'd0, 7'd1, 1'b0);
    send_beat(mrprb_pkg::CMD_READ, 16'h0000, 16'd0, 1'b0, 8'd0, 7'h7F, 1'b0);
    send_beat(mrprb_pkg::CMD_READ, 16'hFFFF, 16'd0, 1'b0, 8'd0, 7'd1, 1'b0);
    send_beat(mrprb_pkg::CMD_FLUSH, 16'd0, 16'd0, 1'b0, 8'd0, 7'd1, 1'b0);
    send_beat(mrprb_pkg::CMD_CLOSE, 16'h0002, 16'd0, 1'b1, 8'd0, 7'd1, 1'b0);
    send_beat(mrprb_pkg::CMD_WRITE, 16'h0002, 16'd0, 1'b0, 8'h5A, 7'd1, 1'b1);
    send_beat(mrprb_pkg::CMD_CLOSE, 16'h0000, 16'd0, 1'b0, 8'd0, 7'd1, 1'b0);
    send_beat(mrprb_pkg::CMD_CLOSE, 16'h0000, 16'd0, 1'b0, 8'd0, 7'd1, 1'b0);
    send_beat(mrprb_pkg::CMD_READ, 16'h0000, 16'd0, 1'b0, 8'd0, 7'd4, 1'b0);
    send_beat(mrprb_pkg::CMD_CLOSE, 16'h0000, 16'd0, 1'b1, 8'd0, 7'd1, 1'b0);
    send_beat(mrprb_pkg::CMD_CLOSE, 16'hFFFF, 16'd0, 1'b0, 8'd0, 7'd1, 1'b0);
    send_beat(mrprb_pkg::CMD_CLOSE, 16'hFFFF, 16'd0, 1'b1, 8'd0, 7'd1, 1'b0);
    send_beat(mrprb_pkg::CMD_READ, 16'hFFFF, 16'd0, 1'b0, 8'd0, 7'd1, 1'b0);
    // Fill every slot to reach the no-free-slot case.
    send_beat(mrprb_pkg::CMD_CREATE, 16'h1000, 16'd0, 1'b0, 8'd0, 7'd1, 1'b0);
    for (int i = 1; i <= SLOTS; i++)
      send_beat(mrprb_pkg::CMD_FORK, 16'(16'h1000 + i), 16'h1000, 1'(i % 2), 8'd0,
                7'd1, 1'b0);
    drain_results();
    // Long receiver stall with the sender still offering beats.
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 12; i++)
        send_beat(mrprb_pkg::CMD_WRITE, 16'h1000, 16'd0, 1'b0, 8'($urandom), 7'd1,
                  i == 11);
    join
    drain_results();
    repeat (10) @(posedge clk);
    // Random sessions: create, forks, write bursts, reads, flushes, closes, unused codes.
    k = 0;
    while (k < 300) begin
      send_beat(mrprb_pkg::CMD_CREATE, pids[$urandom_range(0, 3)] ^
                16'($urandom_range(0, 1)), 16'd0, 1'b0, 8'd0, 7'd1, 1'b0);
      pids[0] = in_ch.pid;
      for (int j = 1; j < 4; j++) pids[j] = 16'($urandom);
      k++;
      for (int t = 0; t < 50 && k < 300; t++) begin
        pick = 4'($urandom_range(0, 15));
        if (pick < 2)
          send_beat(mrprb_pkg::CMD_FORK, pids[$urandom_range(1, 3)],
                    pids[$urandom_range(0, 3)], 1'($urandom_range(0, 1)), 8'd0,
                    7'd1, 1'b0);
        else if (pick < 7) begin
          for (int b = $urandom_range(1, 8); b > 0; b--) begin
            send_beat(mrprb_pkg::CMD_WRITE, pids[$urandom_range(0, 3)], 16'($urandom),
                      1'($urandom), 8'($urandom), 7'($urandom), b == 1);
            k++;
          end
        end else if (pick < 11)
          send_beat(mrprb_pkg::CMD_READ, pids[$urandom_range(0, 3)], 16'($urandom),
                    1'($urandom), 8'($urandom),
                    ($urandom_range(0, 5) == 0) ? 7'h7F : 7'($urandom_range(1, 64)),
                    1'b0);
        else if (pick < 13)
          send_beat(mrprb_pkg::CMD_FLUSH, 16'($urandom), 16'($urandom), 1'($urandom),
                    8'($urandom), 7'd1, 1'b0);
        else if (pick < 14)
          send_beat(mrprb_pkg::CMD_CLOSE, pids[$urandom_range(0, 3)], 16'd0,
                    1'($urandom_range(0, 1)), 8'd0, 7'd1, 1'b0);
        else
          send_beat(($urandom_range(0, 1) == 1) ? CMD_UNUSED_6 : CMD_UNUSED_7,
                    16'($urandom), 16'($urandom), 1'($urandom), 8'($urandom),
                    7'($urandom), 1'($urandom));
        k++;
      end
    end
    drain_results();
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
